// File: rtl/swmm_pkg.sv
// shared types and constants for the sliding window min/max block
package swmm_pkg;

	localparam int DATA_W         = 32;
	localparam int CFG_W          = 7;
	localparam int WINDOW_MAX_DEF = 64;

	// running minimum and maximum held by one cell
	typedef struct packed {
		logic signed [DATA_W-1:0] lo;
		logic signed [DATA_W-1:0] hi;
	} cell_data_t;

	// per-cell control from the top level
	typedef struct packed {
		logic load;
		logic last;
	} cell_ctrl_t;

endpackage

// File: rtl/swmm_cell.sv
// one cell of the min/max chain: folds the new sample into its right neighbor's extremes
module swmm_cell (
	input  logic                              clk,
	input  swmm_pkg::cell_ctrl_t              ctrl,
	input  logic signed [swmm_pkg::DATA_W-1:0] sample,
	input  swmm_pkg::cell_data_t              right,
	output swmm_pkg::cell_data_t              value
);
	import swmm_pkg::*;

	cell_data_t data_q;
	cell_data_t next;

	// the last cell of the window starts a fresh run with the sample alone
	always_comb begin
		if (ctrl.last) begin
			next.lo = sample;
			next.hi = sample;
		end else begin
			next.lo = (sample < right.lo) ? sample : right.lo;
			next.hi = (sample > right.hi) ? sample : right.hi;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= next;
		end
	end

	assign value = data_q;

endmodule

// File: rtl/sliding_window_min_max.sv
// Sliding window minimum and maximum: one signed sample per transfer, one result per transfer
// once window_size samples have arrived since reset or the last window_size write. The window
// state lives in a row of WINDOW_MAX cells; cell j holds the extremes of the last
// (window - j) samples, so every transfer shifts each cell's neighbor value in and folds the
// new sample into it, and cell 0 gives the result. A sample is taken every cycle; the only
// hold-off is a stalled result in the output register. Window size 0 acts as 1, sizes above
// WINDOW_MAX act as WINDOW_MAX. Writing window_size restarts the fill count.
module sliding_window_min_max #(
	parameter int WINDOW_MAX = swmm_pkg::WINDOW_MAX_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [swmm_pkg::DATA_W-1:0] sample,
	input  logic                               cfg_we,
	input  logic        [swmm_pkg::CFG_W-1:0]  cfg_wdata,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [swmm_pkg::DATA_W-1:0] window_min,
	output logic signed [swmm_pkg::DATA_W-1:0] window_max
);
	import swmm_pkg::*;

	localparam int IDX_W = $clog2(WINDOW_MAX);
	localparam int CNT_W = $clog2(WINDOW_MAX + 1);

	logic [CFG_W-1:0]          window_size_q;
	logic [CNT_W-1:0]          seen_q;
	logic                      out_valid_q;

	logic [IDX_W-1:0]          last_idx;
	logic [CNT_W-1:0]          win_eff;
	logic [CNT_W-1:0]          seen_next;
	logic                      accept;
	logic                      emit;
	cell_data_t                cell_val [WINDOW_MAX];

	// effective window, as the index of the farthest cell in use
	always_comb begin
		if (window_size_q == '0) begin
			last_idx = '0;
		end else if (32'(window_size_q) > WINDOW_MAX) begin
			last_idx = IDX_W'(WINDOW_MAX - 1);
		end else begin
			last_idx = IDX_W'(32'(window_size_q) - 32'd1);
		end
	end

	assign win_eff   = CNT_W'(last_idx) + CNT_W'(1);
	assign seen_next = (32'(seen_q) < WINDOW_MAX) ? seen_q + CNT_W'(1) : seen_q;
	assign emit      = seen_next >= win_eff;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
		cell_ctrl_t ctrl;
		cell_data_t right;

		assign ctrl.load = accept;
		assign ctrl.last = (IDX_W'(j) == last_idx);

		if (j == WINDOW_MAX - 1) begin : g_end
			// never the source of a live value: the last cell in use always reloads
			assign right.lo = sample;
			assign right.hi = sample;
		end else begin : g_mid
			assign right = cell_val[j+1];
		end

		swmm_cell u_cell (
			.clk    (clk),
			.ctrl   (ctrl),
			.sample (sample),
			.right  (right),
			.value  (cell_val[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= CFG_W'(1);
			seen_q        <= '0;
		end else if (cfg_we) begin
			window_size_q <= cfg_wdata;
			seen_q        <= '0;
		end else if (accept) begin
			seen_q <= seen_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// cell 0 loads only on an input transfer, so it doubles as the output register
	assign out_valid  = out_valid_q;
	assign window_min = cell_val[0].lo;
	assign window_max = cell_val[0].hi;

endmodule

// File: rtl/swmm_checker.sv
// port-level checks for the sliding window min/max block
module swmm_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic signed [swmm_pkg::DATA_W-1:0] sample,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [swmm_pkg::DATA_W-1:0] window_min,
	input logic signed [swmm_pkg::DATA_W-1:0] window_max
);
	import swmm_pkg::*;

	// a stalled result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(window_min) && $stable(window_max))
		else $error("result changed while stalled");

	// minimum never exceeds maximum
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> window_min <= window_max)
		else $error("window_min above window_max");

	// input is only held off by a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	// a new result only follows an input transfer
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall))
		else $error("result without input transfer");

	// a sample transfer refreshes the result register from that sample's window
	a_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid || (window_min <= $past(sample)
			&& window_max >= $past(sample)))
		else $error("result does not cover the newest sample");

endmodule

bind sliding_window_min_max swmm_checker u_swmm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.sample     (sample),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.window_min (window_min),
	.window_max (window_max)
);

// File: sim/sliding_window_min_max_tb.sv
// testbench for sliding_window_min_max: directed and random sample streams checked against a deque predictor
`timescale 1ns / 100ps

module sliding_window_min_max_tb;

	localparam int DATA_W        = swmm_pkg::DATA_W;
	localparam int CFG_W         = swmm_pkg::CFG_W;
	localparam int WINDOW_MAX    = swmm_pkg::WINDOW_MAX_DEF;
	localparam int LATENCY_SLACK = 4;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 800;
	localparam int CALM_ITEMS    = 200;

	localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

	// stream shapes for random phases
	typedef enum int {
		SHAPE_FULL,
		SHAPE_NARROW,
		SHAPE_EXTREME,
		SHAPE_WALK
	} stream_shape_t;

	typedef struct {
		logic signed [DATA_W-1:0] val;
		logic        [31:0]       pos;
	} chain_entry_t;

	logic                                  clk;
	logic                                  arst_n;
	logic                                  in_valid;
	logic                                  in_stall;
	logic signed [DATA_W-1:0]              sample;
	logic                                  cfg_we;
	logic        [swmm_pkg::CFG_W-1:0]     cfg_wdata;
	logic                                  out_valid;
	logic                                  out_stall;
	logic signed [DATA_W-1:0]              window_min;
	logic signed [DATA_W-1:0]              window_max;

	// predictor state
	chain_entry_t              min_chain[$];
	chain_entry_t              max_chain[$];
	logic [swmm_pkg::CFG_W-1:0] window_reg;
	logic [31:0]               sample_pos;
	int unsigned               fill_count;
	swmm_pkg::cell_data_t      expected_extremes[$];

	int                        errors;
	int                        cycle_count;
	logic                      calm;
	logic signed [DATA_W-1:0]  walk_val;

	sliding_window_min_max #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.window_min(window_min),
		.window_max(window_max)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 30);
	end

	function automatic logic [31:0] active_span(input logic [swmm_pkg::CFG_W-1:0] w);
		if (w == 0)
			return 32'd1;
		if (w > WINDOW_MAX)
			return WINDOW_MAX;
		return {25'd0, w};
	endfunction

	// advance both deques by one sample and queue the window extremes once the window is full
	function automatic void fold_sample(input logic signed [DATA_W-1:0] v);
		chain_entry_t         e;
		logic [31:0]          span;
		swmm_pkg::cell_data_t res;
		span  = active_span(window_reg);
		e.val = v;
		e.pos = sample_pos;
		while (min_chain.size() > 0 && (sample_pos - min_chain[0].pos) >= span)
			void'(min_chain.pop_front());
		while (max_chain.size() > 0 && (sample_pos - max_chain[0].pos) >= span)
			void'(max_chain.pop_front());
		while (min_chain.size() > 0 && min_chain[$].val > v)
			void'(min_chain.pop_back());
		while (max_chain.size() > 0 && max_chain[$].val < v)
			void'(max_chain.pop_back());
		min_chain.push_back(e);
		max_chain.push_back(e);
		sample_pos++;
		if (fill_count < WINDOW_MAX)
			fill_count++;
		if (fill_count >= span) begin
			res.lo = min_chain[0].val;
			res.hi = max_chain[0].val;
			expected_extremes.push_back(res);
		end
	endfunction

	function automatic logic signed [DATA_W-1:0] gen_sample(input stream_shape_t shape);
		case (shape)
			SHAPE_NARROW:  return int'($urandom_range(6)) - 3;
			SHAPE_EXTREME: begin
				case ($urandom_range(3))
					0:       return MOST_NEG;
					1:       return MOST_POS;
					2:       return '0;
					default: return -1;
				endcase
			end
			SHAPE_WALK: begin
				walk_val = walk_val + int'($urandom_range(8)) - 4;
				return walk_val;
			end
			default: return $urandom;
		endcase
	endfunction

	// called at a falling edge, returns at a falling edge with in_valid still high
	task automatic send_sample(input logic signed [DATA_W-1:0] v);
		if (!calm && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample   <= v;
		do
			@(posedge clk);
		while (in_stall);
		fold_sample(v);
		@(negedge clk);
	endtask

	// no transfer until every expected result is out, then let samples with no result settle
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (expected_extremes.size() != 0)
			@(negedge clk);
		repeat (LATENCY_SLACK) @(negedge clk);
	endtask

	task automatic write_window(input logic [swmm_pkg::CFG_W-1:0] w);
		hold_until_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(negedge clk);
		cfg_we     <= 1'b0;
		window_reg  = w;
		fill_count  = 0;
	endtask

	// reset window of one: every sample is its own min and max
	task automatic test_reset_window();
		send_sample(MOST_NEG);
		send_sample(MOST_POS);
		send_sample('0);
		send_sample(-1);
		send_sample(1);
	endtask

	task automatic test_window_zero();
		write_window('0);
		send_sample(MOST_POS);
		send_sample(MOST_NEG);
		send_sample(5);
	endtask

	// equal values stay in the deques, dominated tails get popped
	task automatic test_equal_and_dominated();
		write_window(3);
		send_sample(7);
		send_sample(7);
		send_sample(7);
		send_sample(-2);
		send_sample(9);
		send_sample(9);
		send_sample(-2);
		send_sample(5);
	endtask

	// rewriting the size during fill restarts the count, deque contents carry over
	task automatic test_write_mid_fill();
		write_window(4);
		send_sample(MOST_POS);
		send_sample(MOST_NEG);
		write_window(2);
		send_sample(3);
		send_sample(-3);
		send_sample(0);
	endtask

	task automatic test_random_phases();
		int                         sent;
		int                         span_len;
		logic [swmm_pkg::CFG_W-1:0] w;
		stream_shape_t              shape;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(6))
				0:       w = CFG_W'(1);
				1:       w = CFG_W'(2);
				2:       w = CFG_W'(WINDOW_MAX);
				3:       w = '1;
				4:       w = CFG_W'(WINDOW_MAX + 1);
				5:       w = CFG_W'($urandom_range(WINDOW_MAX, 1));
				default: w = CFG_W'($urandom_range(127));
			endcase
			write_window(w);
			span_len = active_span(w) + $urandom_range(60, 10);
			shape    = stream_shape_t'($urandom_range(3));
			repeat (span_len) begin
				if ($urandom_range(59) == 0)
					hold_until_drained();
				if ($urandom_range(9) == 0)
					send_sample(gen_sample(SHAPE_FULL));
				else
					send_sample(gen_sample(shape));
				sent++;
			end
		end
	endtask

	// back-to-back transfers on both sides with the largest window
	task automatic test_calm_stream();
		write_window(WINDOW_MAX);
		calm = 1'b1;
		repeat (CALM_ITEMS / 2) send_sample(gen_sample(SHAPE_FULL));
		hold_until_drained();
		repeat (CALM_ITEMS / 2) send_sample(gen_sample(SHAPE_WALK));
		calm = 1'b0;
	endtask

	always @(posedge clk) begin : check_result
		swmm_pkg::cell_data_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_extremes.size() == 0) begin
				errors++;
				$display("%0t unexpected result: expected none, actual min %0d max %0d",
					$time, window_min, window_max);
			end else begin
				due = expected_extremes.pop_front();
				if (window_min !== due.lo) begin
					errors++;
					$display("%0t window_min mismatch: expected %0d actual %0d",
						$time, due.lo, window_min);
				end
				if (window_max !== due.hi) begin
					errors++;
					$display("%0t window_max mismatch: expected %0d actual %0d",
						$time, due.hi, window_max);
				end
			end
		end
	end

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		sample      = '0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		out_stall   = 1'b0;
		calm        = 1'b0;
		errors      = 0;
		cycle_count = 0;
		walk_val    = '0;
		window_reg  = 1;
		sample_pos  = '0;
		fill_count  = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_window();
		test_window_zero();
		test_equal_and_dominated();
		test_write_mid_fill();
		test_calm_stream();
		test_random_phases();

		hold_until_drained();
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: sim.f
rtl/swmm_pkg.sv
rtl/swmm_cell.sv
rtl/sliding_window_min_max.sv
rtl/swmm_checker.sv
sim/sliding_window_min_max_tb.sv
